>>> sv/pbo_pkg.sv
// Shared types and constants of the band-limited oscillator.
// Used by the interfaces, the controller, the datapath and the top level.
package pbo_pkg;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_LOAD  = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam logic [1:0] WAVE_SAW      = 2'd0;
   localparam logic [1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
   localparam logic [1:0] WAVE_SINE     = 2'd3;

   localparam logic [1:0] REG_WAVEFORM  = 2'd0;
   localparam logic [1:0] REG_INCREMENT = 2'd1;
   localparam logic [1:0] REG_PULSE     = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WINDOW,
      ST_NEXT,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_ACCUMULATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_phase;
      logic load_phase;
      logic start;
      logic select_m;
      logic window;
      logic div_step;
      logic multiply;
      logic accumulate;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] wave;
      logic       active;
      logic       div_last;
      logic       out_free;
   } status_type;

   // Long division by shift and subtract, used while building the sine table.
   function automatic longint unsigned div_u64(input longint unsigned n,
                                               input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-wave sine entry, evaluated at elaboration only.
   function automatic longint sine_entry(input int i, input int stb, input int sb);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint unsigned div;
      longint sum;
      longint v;
      a = (longint'(i) * HALF_PI_Q30) >> stb;
      a2 = (a * a) >> 30;
      term = a;
      sum = longint'(a);
      for (int k = 1; k <= 7; k++) begin
         case (k)
            1: div = 6;
            2: div = 20;
            3: div = 42;
            4: div = 72;
            5: div = 110;
            6: div = 156;
            default: div = 210;
         endcase
         term = div_u64((term * a2) >> 30, div);
         if (k[0] == 1'b1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = longint'(((longint'(sum) << (sb - 1)) + (longint'(1) << 29)) >> 30);
      if (v > (longint'(1) << (sb - 1)) - 1) v = (longint'(1) << (sb - 1)) - 1;
      return v;
   endfunction

endpackage

>>> sv/pbo_ifs.sv
// Handshake interfaces of the oscillator: request, response and register write.
// Widths follow the parameters of the top level; uses pbo_pkg for the index width.
interface pbo_req_if #(parameter int PHASE_BITS = 24);
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [PHASE_BITS-1:0] phase_value;
   modport source (output valid, output func, output phase_value, input ready);
   modport sink (input valid, input func, input phase_value, output ready);
endinterface

interface pbo_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface pbo_csr_if #(parameter int DATA_BITS = 25);
   logic                                valid;
   logic                                ready;
   logic [pbo_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [DATA_BITS-1:0]                data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/pbo_ctrl.sv
// Sequencer of the oscillator: decodes requests and steps the datapath.
// Depends on pbo_pkg for the state, command and status types.
module pbo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   output logic                req_ready,
   input  pbo_pkg::status_type status,
   output pbo_pkg::cmd_type    cmd
);

   pbo_pkg::state_type state_ff, state_in;
   logic second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pbo_pkg::ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pbo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  pbo_pkg::FUNC_TICK:  state_in = pbo_pkg::ST_START;
                  pbo_pkg::FUNC_CLEAR: cmd.clear_phase = 1'b1;
                  pbo_pkg::FUNC_LOAD:  cmd.load_phase = 1'b1;
                  default: ;
               endcase
            end
         end
         pbo_pkg::ST_START: begin
            cmd.start = 1'b1;
            second_in = 1'b0;
            if (status.wave inside {pbo_pkg::WAVE_SAW, pbo_pkg::WAVE_SQUARE})
               state_in = pbo_pkg::ST_WINDOW;
            else
               state_in = pbo_pkg::ST_FINISH;
         end
         pbo_pkg::ST_WINDOW: begin
            cmd.window = 1'b1;
            if (status.active) state_in = pbo_pkg::ST_DIVIDE;
            else if (status.wave == pbo_pkg::WAVE_SQUARE && !second_ff)
               state_in = pbo_pkg::ST_NEXT;
            else state_in = pbo_pkg::ST_FINISH;
         end
         pbo_pkg::ST_NEXT: begin
            cmd.select_m = 1'b1;
            second_in = 1'b1;
            state_in = pbo_pkg::ST_WINDOW;
         end
         pbo_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = pbo_pkg::ST_MULTIPLY;
         end
         pbo_pkg::ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in = pbo_pkg::ST_ACCUMULATE;
         end
         pbo_pkg::ST_ACCUMULATE: begin
            cmd.accumulate = 1'b1;
            if (status.wave == pbo_pkg::WAVE_SQUARE && !second_ff)
               state_in = pbo_pkg::ST_NEXT;
            else state_in = pbo_pkg::ST_FINISH;
         end
         pbo_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = pbo_pkg::ST_IDLE;
            end
         end
         default: state_in = pbo_pkg::ST_IDLE;
      endcase
   end

endmodule

>>> sv/pbo_dp.sv
// Datapath of the oscillator: phase, settings, residual divider and multiplier,
// sine table, rounding and the output register. Depends on pbo_pkg.
module pbo_dp #(
   parameter int PHASE_BITS      = 24,
   parameter int SAMPLE_BITS     = 16,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pbo_pkg::cmd_type              cmd,
   output pbo_pkg::status_type           status,
   input  logic [PHASE_BITS-1:0]         req_phase_value,
   input  logic                          csr_valid,
   input  logic [pbo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PHASE_BITS:0]           csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample
);

   localparam int PB = PHASE_BITS;
   localparam int AW = PB + 4;
   localparam int WW = AW + SAMPLE_BITS;
   localparam int CW = $clog2(PB);
   localparam int SN = 1 << SINE_TABLE_BITS;
   localparam int NB = SINE_TABLE_BITS + 1;
   localparam logic [PB:0] ONE_U = (PB + 1)'(1) << PB;
   localparam logic signed [AW-1:0] ONE_S = AW'(1) << PB;
   localparam logic signed [WW-1:0] SMP_MAX = (WW'(1) <<< (SAMPLE_BITS - 1)) - WW'(1);
   localparam logic signed [WW-1:0] SMP_MIN = -(WW'(1) <<< (SAMPLE_BITS - 1));

   logic [1:0]              wave_ff;
   logic [PB-1:0]           inc_ff;
   logic [PB:0]             pw_ff;
   logic [PB-1:0]           phase_ff;
   logic [PB-1:0]           x_ff;
   logic                    sub_ff;
   logic                    rising_ff;
   logic [PB-1:0]           rem_ff;
   logic [PB-1:0]           q_ff;
   logic [CW-1:0]           cnt_ff;
   logic [2*PB-1:0]         prod_ff;
   logic signed [AW-1:0]    acc_ff;
   logic                    rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;

   // Register writes; the pulse width is clamped to one full period (1.0).
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= pbo_pkg::WAVE_SAW;
         inc_ff  <= PB'(153791);
         pw_ff   <= ONE_U >> 1;
      end else if (csr_valid) begin
         case (csr_index)
            pbo_pkg::REG_WAVEFORM:  wave_ff <= csr_data[1:0];
            pbo_pkg::REG_INCREMENT: inc_ff <= csr_data[PB-1:0];
            pbo_pkg::REG_PULSE:     pw_ff <= (csr_data > ONE_U) ? ONE_U : csr_data;
            default: ;
         endcase
      end
   end

   // Window test of the residual for the current operand.
   logic [PB:0]   win_sum;
   logic          rising, falling, active;
   logic [PB:0]   fall_num;
   assign win_sum  = {1'b0, x_ff} + {1'b0, inc_ff};
   assign rising   = x_ff < inc_ff;
   assign falling  = win_sum > ONE_U;
   assign active   = (inc_ff != '0) && (rising || falling);
   assign fall_num = ONE_U - {1'b0, x_ff};

   logic [PB:0] m_sum;
   assign m_sum = {1'b0, phase_ff} + (ONE_U - pw_ff);

   logic [PB:0] rem2;
   assign rem2 = {rem_ff, 1'b0};

   logic signed [AW-1:0] qx, hix, resid;
   assign qx    = AW'(q_ff);
   assign hix   = AW'(prod_ff[2*PB-1:PB]);
   assign resid = rising_ff ? (qx <<< 1) - hix - ONE_S : hix - (qx <<< 1) + ONE_S;

   logic signed [AW-1:0] px;
   assign px = AW'(phase_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff   <= phase_ff;
         cnt_ff <= '0;
         case (wave_ff)
            pbo_pkg::WAVE_SAW: begin
               acc_ff <= (px <<< 1) - ONE_S;
               sub_ff <= 1'b1;
            end
            pbo_pkg::WAVE_SQUARE: begin
               acc_ff <= ({1'b0, phase_ff} < pw_ff) ? ONE_S : -ONE_S;
               sub_ff <= 1'b0;
            end
            default: begin
               acc_ff <= phase_ff[PB-1] ? (ONE_S + ONE_S + ONE_S) - (px <<< 2)
                                        : (px <<< 2) - ONE_S;
               sub_ff <= 1'b0;
            end
         endcase
      end
      if (cmd.select_m) begin
         x_ff   <= m_sum[PB-1:0];
         sub_ff <= 1'b1;
      end
      if (cmd.window) begin
         rising_ff <= rising;
         rem_ff    <= rising ? x_ff : fall_num[PB-1:0];
         cnt_ff    <= '0;
      end
      if (cmd.div_step) begin
         // One restoring step; the remainder stays below the increment.
         if (rem2 >= {1'b0, inc_ff}) begin
            rem_ff <= PB'(rem2 - {1'b0, inc_ff});
            q_ff   <= {q_ff[PB-2:0], 1'b1};
         end else begin
            rem_ff <= rem2[PB-1:0];
            q_ff   <= {q_ff[PB-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.multiply) prod_ff <= q_ff * q_ff;
      if (cmd.accumulate) acc_ff <= sub_ff ? acc_ff - resid : acc_ff + resid;
   end

   // Phase accumulator.
   always_ff @(posedge clock) begin
      if (reset) phase_ff <= '0;
      else if (cmd.clear_phase) phase_ff <= '0;
      else if (cmd.load_phase) phase_ff <= req_phase_value;
      else if (cmd.finish) phase_ff <= phase_ff + inc_ff;
   end

   // Quarter-wave sine table.
   logic [SAMPLE_BITS-1:0] sine_rom [0:SN];
   for (genvar g = 0; g <= SN; g++) begin : g_rom
      localparam longint ENTRY = pbo_pkg::sine_entry(g, SINE_TABLE_BITS, SAMPLE_BITS);
      assign sine_rom[g] = SAMPLE_BITS'(ENTRY);
   end

   logic [PB-2+SINE_TABLE_BITS-1:0] idx_ext;
   logic [SINE_TABLE_BITS-1:0]      idx;
   logic [NB-1:0]                   idx_rd;
   logic signed [SAMPLE_BITS-1:0]   sine_val;
   assign idx_ext  = {phase_ff[PB-3:0], {SINE_TABLE_BITS{1'b0}}};
   assign idx      = idx_ext[PB-3+SINE_TABLE_BITS -: SINE_TABLE_BITS];
   assign idx_rd   = phase_ff[PB-2] ? NB'(SN) - {1'b0, idx} : {1'b0, idx};
   assign sine_val = phase_ff[PB-1] ? -$signed(sine_rom[idx_rd]) : $signed(sine_rom[idx_rd]);

   // Round to the sample format and saturate.
   logic signed [WW-1:0] wide, shifted;
   logic signed [SAMPLE_BITS-1:0] rounded;
   assign wide    = (WW'(acc_ff) <<< (SAMPLE_BITS - 1)) + (WW'(1) <<< (PB - 1));
   assign shifted = wide >>> PB;
   assign rounded = (shifted > SMP_MAX) ? SAMPLE_BITS'(SMP_MAX) :
                    (shifted < SMP_MIN) ? SAMPLE_BITS'(SMP_MIN) : SAMPLE_BITS'(shifted);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) sample_ff <= (wave_ff == pbo_pkg::WAVE_SINE) ? sine_val : rounded;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = sample_ff;
   assign status.wave     = wave_ff;
   assign status.active   = active;
   assign status.div_last = cnt_ff == CW'(PB - 1);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

>>> sv/polyblep_oscillator.sv
// Channel | Dir | Payload
// req_ch  | in  | func, phase_value
// rsp_ch  | out | sample (signed Q1.15)
// csr_ch  | in  | index, data (always ready)
// A tick of the square wave may run the shared restoring divider (one quotient bit per
// cycle) twice, once per edge; saw runs it at most once, triangle and sine not at all.
// Phase reset and load requests are done in the idle state. Reset is synchronous and restores defaults.
// A finished sample waits in the output register; a later tick stalls only at its end.
// Top level: joins the sequencer and the datapath; depends on pbo_pkg and pbo_ifs.
module polyblep_oscillator #(
   parameter int PHASE_BITS      = 24,
   parameter int SAMPLE_BITS     = 16,
   parameter int SINE_TABLE_BITS = 8
) (
   input logic      clock,
   input logic      reset,
   pbo_req_if.sink  req_ch,
   pbo_rsp_if.source rsp_ch,
   pbo_csr_if.sink  csr_ch
);

   pbo_pkg::cmd_type    cmd;
   pbo_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   pbo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pbo_dp #(
      .PHASE_BITS      (PHASE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_phase_value (req_ch.phase_value),
      .csr_valid       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_sample      (rsp_ch.sample)
   );

endmodule

>>> tb/sv/pbo_checker.sv
// Scoreboard of the band-limited oscillator: watches the request, response and register
// write channels, predicts every sample and compares it. Depends on pbo_pkg and pbo_ifs.
module pbo_checker (
   input  logic clock,
   input  logic reset,
   pbo_req_if   req_mon,
   pbo_rsp_if   rsp_mon,
   pbo_csr_if   csr_mon,
   output int   fail_count,
   output int   pending,
   output int   samples_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE = 64'sd1 << 24;

   longint      quarter_sine [0:256];
   logic [1:0]  wave_sel;
   logic [23:0] phase_step;
   logic [24:0] duty;
   logic [23:0] phase;
   shortint     expected_samples [$];

   // Quarter-wave table from a Q30 Taylor series through the 15th power.
   initial begin
      longint unsigned a, a2, term;
      longint sum, v;
      for (int i = 0; i <= 256; i++) begin
         a = (longint'(i) * 64'd1686629713) / 256;
         a2 = (a * a) >> 30;
         term = a;
         sum = longint'(a);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         v = ((sum << 15) + (64'sd1 << 29)) >>> 30;
         if (v > 32767) v = 32767;
         quarter_sine[i] = v;
      end
   end

   function automatic longint blep_residual(longint p, longint d);
      longint t;
      if (d == 0) return 0;
      if (p < d) begin
         t = (p << 24) / d;
         return 2 * t - ((t * t) >>> 24) - ONE;
      end
      if (p > ONE - d) begin
         t = ((ONE - p) << 24) / d;
         return ((t * t) >>> 24) - 2 * t + ONE;
      end
      return 0;
   endfunction

   function automatic shortint to_q15(longint v);
      longint r;
      r = (((v + 8 * ONE) <<< 15) + (ONE >>> 1)) >>> 24;
      r = r - 8 * 32768;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return shortint'(r);
   endfunction

   function automatic shortint oscillator_sample(logic [1:0] w, logic [23:0] ph,
                                                 logic [23:0] step, logic [24:0] pw);
      longint p, d, m, v;
      int idx;
      p = longint'(ph);
      d = longint'(step);
      case (w)
         pbo_pkg::WAVE_SAW: return to_q15(2 * p - ONE - blep_residual(p, d));
         pbo_pkg::WAVE_SQUARE: begin
            m = p + ONE - longint'(pw);
            if (m >= ONE) m = m - ONE;
            v = (p < longint'(pw)) ? ONE : -ONE;
            return to_q15(v + blep_residual(p, d) - blep_residual(m, d));
         end
         pbo_pkg::WAVE_TRIANGLE: begin
            if (p < (ONE >>> 1)) return to_q15(4 * p - ONE);
            return to_q15(3 * ONE - 4 * p);
         end
         default: begin
            idx = int'(ph[21:14]);
            if (ph[22]) idx = 256 - idx;
            v = quarter_sine[idx];
            return shortint'(ph[23] ? -v : v);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      shortint want;
      if (reset) begin
         wave_sel = pbo_pkg::WAVE_SAW;
         phase_step = 24'd153791;
         duty = 25'h0800000;
         phase = '0;
         fail_count = 0;
         samples_checked = 0;
         expected_samples.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               pbo_pkg::REG_WAVEFORM:  wave_sel = csr_mon.data[1:0];
               pbo_pkg::REG_INCREMENT: phase_step = csr_mon.data[23:0];
               pbo_pkg::REG_PULSE:
                  duty = (csr_mon.data > 25'h1000000) ? 25'h1000000 : csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.func)
               pbo_pkg::FUNC_TICK: begin
                  expected_samples.push_back(oscillator_sample(wave_sel, phase, phase_step,
                                                               duty));
                  phase = phase + phase_step;
               end
               pbo_pkg::FUNC_CLEAR: phase = '0;
               pbo_pkg::FUNC_LOAD:  phase = req_mon.phase_value;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected sample %0d with none pending", $realtime,
                           rsp_mon.sample);
            end else begin
               want = expected_samples.pop_front();
               samples_checked++;
               if (rsp_mon.sample !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: sample mismatch, expected %0d, got %0d", $realtime,
                              want, rsp_mon.sample);
               end
            end
         end
      end
      pending = expected_samples.size();
   end

endmodule

>>> tb/sv/tb_polyblep_oscillator.sv
// Top of the oscillator testbench: clock, reset, directed and random stimulus, verdict.
// Depends on pbo_pkg, pbo_ifs, the oscillator RTL and pbo_checker.
module tb_polyblep_oscillator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE = 64;

   logic clock = 1'b0;
   logic reset;
   int   fail_count, pending, samples_checked;
   int   cycles;
   bit   steady;
   int   request_count;
   logic [24:0] duty_now;

   pbo_req_if #(.PHASE_BITS(24))  req_ch ();
   pbo_rsp_if #(.SAMPLE_BITS(16)) rsp_ch ();
   pbo_csr_if #(.DATA_BITS(25))   csr_ch ();

   polyblep_oscillator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pbo_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_mon         (csr_ch),
      .fail_count      (fail_count),
      .pending         (pending),
      .samples_checked (samples_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d samples outstanding", pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // The valid line is left high after a transfer so back-to-back requests need no toggle.
   task automatic send_request(logic [1:0] f, logic [23:0] pv);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.phase_value <= pv;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      request_count++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [24:0] value);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == pbo_pkg::REG_PULSE) duty_now = value;
   endtask

   task automatic random_settings();
      logic [23:0] step;
      logic [24:0] pw;
      case ($urandom_range(0, 5))
         0: step = '0;
         1: step = 24'h800000;
         2: step = 24'($urandom_range(1, 15));
         3: step = 24'($urandom);
         default: step = 24'($urandom_range(1, 400000));
      endcase
      case ($urandom_range(0, 4))
         0: pw = '0;
         1: pw = 25'h1000000;
         2: pw = 25'($urandom);
         default: pw = 25'($urandom_range(0, 25'h1000000));
      endcase
      write_reg(pbo_pkg::REG_WAVEFORM, 25'($urandom_range(0, 3)));
      write_reg(pbo_pkg::REG_INCREMENT, {1'b0, step});
      write_reg(pbo_pkg::REG_PULSE, pw);
   endtask

   // Mostly ticks; loads favor phases near the step edges and the duty edge.
   task automatic random_request();
      int pick;
      logic [23:0] pv;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: pv = 24'($urandom_range(0, 4095));
         1: pv = 24'hFFFFFF - 24'($urandom_range(0, 4095));
         2: pv = duty_now[23:0] + 24'($urandom_range(0, 2047)) - 24'd1024;
         default: pv = 24'($urandom);
      endcase
      if (pick < 78) send_request(pbo_pkg::FUNC_TICK, 24'($urandom));
      else if (pick < 85) send_request(pbo_pkg::FUNC_CLEAR, 24'($urandom));
      else if (pick < 95) send_request(pbo_pkg::FUNC_LOAD, pv);
      else send_request(pbo_pkg::FUNC_SPARE, 24'($urandom));
   endtask

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   initial begin
      int waited;
      reset = 1'b1;
      steady = 1'b0;
      request_count = 0;
      duty_now = 25'h0800000;
      req_ch.valid = 1'b0;
      req_ch.func = pbo_pkg::FUNC_TICK;
      req_ch.phase_value = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = pbo_pkg::REG_WAVEFORM;
      csr_ch.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: saw with the rising residual at phase zero and the falling one near 1.0.
      send_request(pbo_pkg::FUNC_TICK, 24'h000000);
      send_request(pbo_pkg::FUNC_LOAD, 24'hFFFFF0);
      send_request(pbo_pkg::FUNC_TICK, 24'hFFFFFF);
      send_request(pbo_pkg::FUNC_CLEAR, 24'hFFFFFF);
      send_request(pbo_pkg::FUNC_TICK, 24'h000000);
      send_request(pbo_pkg::FUNC_SPARE, 24'hFFFFFF);
      // Square with a zero step and a duty above one, which is clamped.
      write_reg(pbo_pkg::REG_WAVEFORM, 25'(pbo_pkg::WAVE_SQUARE));
      write_reg(pbo_pkg::REG_INCREMENT, 25'd0);
      write_reg(pbo_pkg::REG_PULSE, 25'h1FFFFFF);
      send_request(pbo_pkg::FUNC_TICK, 24'h0);
      send_request(pbo_pkg::FUNC_LOAD, 24'h800000);
      send_request(pbo_pkg::FUNC_TICK, 24'h0);
      // Step above one half, where both residual windows overlap, and a zero duty.
      write_reg(pbo_pkg::REG_INCREMENT, 25'hFFFFFF);
      write_reg(pbo_pkg::REG_PULSE, 25'd0);
      send_request(pbo_pkg::FUNC_TICK, 24'h0);
      send_request(pbo_pkg::FUNC_LOAD, 24'h000010);
      send_request(pbo_pkg::FUNC_TICK, 24'h0);
      write_reg(pbo_pkg::REG_PULSE, 25'h1000000);
      send_request(pbo_pkg::FUNC_TICK, 24'h0);
      // Triangle at the half-cycle step: bottom, peak, bottom.
      write_reg(pbo_pkg::REG_WAVEFORM, 25'(pbo_pkg::WAVE_TRIANGLE));
      write_reg(pbo_pkg::REG_INCREMENT, 25'h800000);
      send_request(pbo_pkg::FUNC_LOAD, 24'h0);
      repeat (3) send_request(pbo_pkg::FUNC_TICK, 24'h0);
      // Sine stepping by quarters, then the last phase of the first quadrant.
      write_reg(pbo_pkg::REG_WAVEFORM, 25'(pbo_pkg::WAVE_SINE));
      write_reg(pbo_pkg::REG_INCREMENT, 25'h400000);
      send_request(pbo_pkg::FUNC_LOAD, 24'h0);
      repeat (4) send_request(pbo_pkg::FUNC_TICK, 24'h0);
      send_request(pbo_pkg::FUNC_LOAD, 24'h3FFFFF);
      send_request(pbo_pkg::FUNC_TICK, 24'h0);

      for (int ph = 0; ph < 12; ph++) begin
         random_settings();
         steady = (ph % 3 == 2);
         for (int n = 0; n < 88; n++) begin
            // Let the block run dry once in a while before carrying on.
            if (n == 44 && ph % 4 == 1) drain();
            random_request();
         end
         steady = 1'b0;
      end

      drain();
      waited = 0;
      while (pending != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d requests over all four waveforms, %0d samples compared;",
               request_count, samples_checked);
      $display("steps from zero to full scale, duty from zero to clamped, loads and clears.");
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("failures: %0d, samples still outstanding: %0d", fail_count, pending);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
